// File: rtl/risa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risa_pkg: shared types and constants of the slope angle unit
// Field widths, fixed-point formats, the CORDIC angle table and the item
// type that travels from the front end to the angle engine.
// ----------------------------------------------------------------------------
package risa_pkg;

  localparam int unsigned MAX_COLS_DEF = 2048;
  localparam int unsigned DEPTH_W      = 16;
  localparam int unsigned TRIG_W       = 16;
  localparam int unsigned CFG_W        = 12;
  localparam int unsigned WID_W        = CFG_W + 1;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned DIFF_W       = 25;
  localparam int unsigned NORM_W       = 30;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned Z_W          = 17;
  localparam int unsigned ANGLE_W      = 15;
  localparam int unsigned PEAK_W       = 16;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 15'd25736;
  localparam logic [PEAK_W-1:0]  PEAK_RESET = 16'hC000;
  localparam logic [STEP_W-1:0]  LAST_STEP  = 4'd15;
  localparam logic               REG_IMAGE_WIDTH = 1'b0;

  typedef struct packed {
    logic              first_row;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
  } item_t;

  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] r;
    case (i)
      4'd0:    r = 15'd12868;
      4'd1:    r = 15'd7596;
      4'd2:    r = 15'd4014;
      4'd3:    r = 15'd2037;
      4'd4:    r = 15'd1023;
      4'd5:    r = 15'd512;
      4'd6:    r = 15'd256;
      4'd7:    r = 15'd128;
      4'd8:    r = 15'd64;
      4'd9:    r = 15'd32;
      4'd10:   r = 15'd16;
      4'd11:   r = 15'd8;
      4'd12:   r = 15'd4;
      4'd13:   r = 15'd2;
      4'd14:   r = 15'd1;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/range_image_slope_angle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_image_slope_angle_unit: slope angle of range-image pixels
// Top level with stream ports, the width register and the assertions.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each yields one result: the angle to the
// pixel directly above as unsigned Q1.14 radians, zero on the first row of an
// image, together with the largest angle seen since reset. The front end
// handles each pixel in three steps (intake, multiply with the line store
// read, difference with the line store write), takes no new pixel until the
// last is through and hands its work to a two-entry queue. The angle engine
// is a single iterative CORDIC unit and sets the throughput: it takes the
// item, runs the normalization, sixteen rotation steps and the load of the
// output register, and takes no new item before that. Pixels on the first
// row or with a horizontal, vertical or zero difference skip normalization
// and rotation in the engine, so the front end sets their pace. A stalled
// output holds the engine and, once the queue is full, the input. The line
// store is not cleared after reset; the first row of each image fills it.
// ----------------------------------------------------------------------------
module range_image_slope_angle_unit #(
  parameter int unsigned MAX_COLS = risa_pkg::MAX_COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // depth [15:0], beam_cos [31:16], beam_sin [47:32]
  input  logic [47:0] s_axis_tdata,
  // image_start [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slope_angle [14:0], peak_angle [30:15], zero [31]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [risa_pkg::PADDR_W-1:0] paddr,
  input  logic [risa_pkg::PDATA_W-1:0] pwdata,
  output logic [risa_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);

  logic [risa_pkg::CFG_W-1:0] image_width_q;
  logic push, full, pop, empty;
  risa_pkg::item_t push_item, pop_item;
  logic [risa_pkg::ANGLE_W-1:0] slope;
  logic [risa_pkg::PEAK_W-1:0] peak;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == risa_pkg::REG_IMAGE_WIDTH) ?
                  risa_pkg::PDATA_W'(image_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= risa_pkg::CFG_W'(2048);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == risa_pkg::REG_IMAGE_WIDTH) begin
      image_width_q <= pwdata[risa_pkg::CFG_W-1:0];
    end
  end

  risa_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_width_i(image_width_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .depth_i      (s_axis_tdata[15:0]),
    .beam_cos_i   ($signed(s_axis_tdata[31:16])),
    .beam_sin_i   ($signed(s_axis_tdata[47:32])),
    .image_start_i(s_axis_tuser),
    .push_o       (push),
    .push_item_o  (push_item),
    .full_i       (full)
  );

  risa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .empty_o    (empty)
  );

  risa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!empty),
    .q_item_i   (pop_item),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .slope_o    (slope),
    .peak_o     (peak)
  );

  assign m_axis_tdata = {1'b0, peak, slope};

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty)) else $error("queue read while empty");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> slope <= risa_pkg::ANGLE_MAX)
    else $error("slope angle above pi/2");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && slope != '0) |-> $signed(peak) >= $signed({1'b0, slope}))
    else $error("peak below reported angle");

endmodule

// File: rtl/risa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risa_front: pixel intake, coordinate forming and line store
// Accepts a pixel, tracks the column and whether the row is the first, forms
// x and y, reads the pixel above from the line store, writes the new
// coordinates and queues the absolute differences for the angle engine.
// ----------------------------------------------------------------------------
module risa_front #(
  parameter int unsigned MAX_COLS = risa_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [risa_pkg::CFG_W-1:0]    image_width_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [risa_pkg::DEPTH_W-1:0]  depth_i,
  input  logic signed [risa_pkg::TRIG_W-1:0] beam_cos_i,
  input  logic signed [risa_pkg::TRIG_W-1:0] beam_sin_i,
  input  logic                          image_start_i,
  output logic                          push_o,
  output risa_pkg::item_t               push_item_o,
  input  logic                          full_i
);

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned XY_W  = 2 * risa_pkg::COORD_W;
  localparam int unsigned PROD_W = risa_pkg::DEPTH_W + risa_pkg::TRIG_W + 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIFF = 2'd2;

  logic [1:0] state_q, state_d;
  logic [COL_W-1:0] col_pos_q, col_pos_d;
  logic first_q, first_d;

  logic [COL_W-1:0] col_q;
  logic             item_first_q;
  logic [risa_pkg::DEPTH_W-1:0] depth_q;
  logic signed [risa_pkg::TRIG_W-1:0] cos_q, sin_q;
  logic signed [risa_pkg::COORD_W-1:0] x_q, y_q;
  logic [XY_W-1:0] rd_q;

  logic [XY_W-1:0] line_mem [MAX_COLS];

  logic [risa_pkg::WID_W-1:0] eff_width;
  logic [risa_pkg::WID_W-1:0] col_next;
  logic [COL_W-1:0] col_cur;
  logic first_cur;
  logic accept;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [risa_pkg::COORD_W-1:0] above_x, above_y;
  logic signed [risa_pkg::DIFF_W-1:0] diff_x, diff_y;

  always_comb begin
    eff_width = {1'b0, image_width_i};
    if (eff_width == '0) begin
      eff_width = risa_pkg::WID_W'(1);
    end else if (eff_width > risa_pkg::WID_W'(MAX_COLS)) begin
      eff_width = risa_pkg::WID_W'(MAX_COLS);
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign col_cur    = image_start_i ? '0 : col_pos_q;
  assign first_cur  = image_start_i ? 1'b1 : first_q;
  assign col_next   = risa_pkg::WID_W'(col_cur) + risa_pkg::WID_W'(1);

  assign prod_x = $signed({1'b0, depth_q}) * cos_q;
  assign prod_y = $signed({1'b0, depth_q}) * sin_q;

  assign above_x = rd_q[risa_pkg::COORD_W-1:0];
  assign above_y = rd_q[XY_W-1:risa_pkg::COORD_W];
  assign diff_x  = {x_q[risa_pkg::COORD_W-1], x_q} - {above_x[risa_pkg::COORD_W-1], above_x};
  assign diff_y  = {y_q[risa_pkg::COORD_W-1], y_q} - {above_y[risa_pkg::COORD_W-1], above_y};

  assign push_item_o.first_row = item_first_q;
  assign push_item_o.dx = diff_x[risa_pkg::DIFF_W-1] ? risa_pkg::DIFF_W'(-diff_x) : diff_x;
  assign push_item_o.dy = diff_y[risa_pkg::DIFF_W-1] ? risa_pkg::DIFF_W'(-diff_y) : diff_y;
  assign push_o = (state_q == F_DIFF) && !full_i;

  always_comb begin
    state_d   = state_q;
    col_pos_d = col_pos_q;
    first_d   = first_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL;
          if (col_next >= eff_width) begin
            col_pos_d = '0;
            first_d   = 1'b0;
          end else begin
            col_pos_d = col_next[COL_W-1:0];
            first_d   = first_cur;
          end
        end
      end
      F_MUL: begin
        state_d = F_DIFF;
      end
      F_DIFF: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      col_pos_q <= '0;
      first_q   <= 1'b1;
    end else begin
      state_q   <= state_d;
      col_pos_q <= col_pos_d;
      first_q   <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q        <= col_cur;
      item_first_q <= first_cur;
      depth_q      <= depth_i;
      cos_q        <= beam_cos_i;
      sin_q        <= beam_sin_i;
    end
    if (state_q == F_MUL) begin
      x_q  <= prod_x[risa_pkg::COORD_W+7:8];
      y_q  <= prod_y[risa_pkg::COORD_W+7:8];
      rd_q <= line_mem[col_q];
    end
    if (state_q == F_DIFF) begin
      line_mem[col_q] <= {y_q, x_q};
    end
  end

endmodule

// File: rtl/risa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risa_fifo: two-entry queue between front end and angle engine
// Holds pixel differences so that intake and the CORDIC stall on their own.
// ----------------------------------------------------------------------------
module risa_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  risa_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output risa_pkg::item_t pop_item_o,
  output logic            empty_o
);

  risa_pkg::item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/risa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risa_back: iterative CORDIC angle engine with peak tracking
// Normalizes the differences, runs sixteen vectoring steps on one shared
// add/shift unit, clamps the angle and updates the running peak.
// ----------------------------------------------------------------------------
module risa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  risa_pkg::item_t                q_item_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [risa_pkg::ANGLE_W-1:0]   slope_o,
  output logic [risa_pkg::PEAK_W-1:0]    peak_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [risa_pkg::NORM_W-1:0] nx_q, nx_d, ny_q, ny_d, n_or;
  logic signed [risa_pkg::CORDIC_W-1:0] cx_q, cx_d, cy_q, cy_d, sx, sy;
  logic signed [risa_pkg::Z_W-1:0] z_q, z_d, t_step;
  logic [risa_pkg::STEP_W-1:0] step_q, step_d;
  logic upd_q, upd_d;
  logic out_valid_q, out_valid_d;
  logic [risa_pkg::ANGLE_W-1:0] out_slope_q, out_slope_d, angle;
  logic signed [risa_pkg::PEAK_W-1:0] peak_q, peak_d, out_peak_q, out_peak_d;
  logic load;

  assign n_or   = nx_q | ny_q;
  assign sx     = cx_q >>> step_q;
  assign sy     = cy_q >>> step_q;
  assign t_step = $signed({2'b00, risa_pkg::atan_lut(step_q)});

  always_comb begin
    if (z_q[risa_pkg::Z_W-1]) begin
      angle = '0;
    end else if (z_q > $signed({2'b00, risa_pkg::ANGLE_MAX})) begin
      angle = risa_pkg::ANGLE_MAX;
    end else begin
      angle = z_q[risa_pkg::ANGLE_W-1:0];
    end
  end

  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign slope_o     = out_slope_q;
  assign peak_o      = out_peak_q;

  always_comb begin
    state_d     = state_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    z_d         = z_q;
    step_d      = step_q;
    upd_d       = upd_q;
    peak_d      = peak_q;
    out_slope_d = out_slope_q;
    out_peak_d  = out_peak_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          upd_d = !q_item_i.first_row;
          nx_d  = risa_pkg::NORM_W'(q_item_i.dx);
          ny_d  = risa_pkg::NORM_W'(q_item_i.dy);
          if (q_item_i.first_row || q_item_i.dy == '0) begin
            z_d     = '0;
            state_d = S_DONE;
          end else if (q_item_i.dx == '0) begin
            z_d     = $signed({2'b00, risa_pkg::ANGLE_MAX});
            state_d = S_DONE;
          end else begin
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (n_or[risa_pkg::NORM_W-1]) begin
          cx_d    = risa_pkg::CORDIC_W'(nx_q);
          cy_d    = risa_pkg::CORDIC_W'(ny_q);
          z_d     = '0;
          step_d  = '0;
          state_d = S_ROT;
        end else if (n_or[risa_pkg::NORM_W-1 -: 8] == '0) begin
          nx_d = nx_q << 8;
          ny_d = ny_q << 8;
        end else if (n_or[risa_pkg::NORM_W-1 -: 4] == '0) begin
          nx_d = nx_q << 4;
          ny_d = ny_q << 4;
        end else begin
          nx_d = nx_q << 1;
          ny_d = ny_q << 1;
        end
      end
      S_ROT: begin
        if (cy_q > 0) begin
          cx_d = cx_q + sy;
          cy_d = cy_q - sx;
          z_d  = z_q + t_step;
        end else if (cy_q < 0) begin
          cx_d = cx_q - sy;
          cy_d = cy_q + sx;
          z_d  = z_q - t_step;
        end
        step_d = step_q + risa_pkg::STEP_W'(1);
        if (step_q == risa_pkg::LAST_STEP) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          if (upd_q && $signed({1'b0, angle}) > peak_q) begin
            peak_d = $signed({1'b0, angle});
          end
          out_slope_d = angle;
          out_peak_d  = (upd_q && $signed({1'b0, angle}) > peak_q) ?
                        $signed({1'b0, angle}) : peak_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      peak_q      <= risa_pkg::PEAK_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      peak_q      <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q        <= nx_d;
    ny_q        <= ny_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    z_q         <= z_d;
    step_q      <= step_d;
    upd_q       <= upd_d;
    out_slope_q <= out_slope_d;
    out_peak_q  <= out_peak_d;
  end

endmodule
